### hw/rtl/fpd_pkg.sv
`timescale 1ns / 1ps
// Shared constants, tables and types of the fisheye point distortion pipeline.
package fpd_pkg;

   // Field and register widths
   localparam int POS_W     = 16;
   localparam int FOCAL_W   = 16;
   localparam int COEF_W    = 20;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 20;

   // Register map
   localparam logic [CSR_IDX_W-1:0] REG_FOCAL_X  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FOCAL_Y  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_X = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Y = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_K1  = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_K2  = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_K3  = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_K4  = 4'd7;

   localparam logic [FOCAL_W-1:0] FOCAL_RESET    = 16'd8192;
   localparam logic [FOCAL_W-1:0] CENTER_X_RESET = 16'd10240;
   localparam logic [FOCAL_W-1:0] CENTER_Y_RESET = 16'd7680;

   // Datapath widths
   localparam int DX_W   = 18;          // offset from principal point
   localparam int NORM_Q = 31;          // magnitude bits of a normalised coordinate
   localparam int R_W    = 32;          // radius, Q.16
   localparam int TH_W   = 17;          // theta, Q.16, clamped to half pi
   localparam int QUO2_Q = 18;          // magnitude bits of the final offset
   localparam int NUM2_W = 48;          // magnitude of offset times theta_d

   // Arctangent unit
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_XY_W  = 36;
   localparam int CORDIC_Z_W   = 20;
   localparam int ONE_Q16      = 65536;
   localparam logic [TH_W-1:0] HALF_PI_Q16 = 17'd102944;
   localparam logic [TH_W-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
      17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
      17'd256, 17'd128, 17'd64, 17'd32, 17'd16, 17'd8, 17'd4, 17'd2
   };

   // Values that ride along with an item through the long units
   typedef struct packed {
      logic signed [DX_W-1:0] dx;
      logic signed [DX_W-1:0] dy;
      logic [R_W-1:0]         r;
      logic [TH_W-1:0]        th;
   } fpd_carry_type;

endpackage

### hw/rtl/fpd_divider.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, saturating on overflow.
module fpd_divider #(
   parameter int NUM_W = fpd_pkg::NORM_Q + 2,
   parameter int DEN_W = fpd_pkg::FOCAL_W,
   parameter int QUO_W = fpd_pkg::NORM_Q,
   parameter int SB_W  = $bits(fpd_pkg::fpd_carry_type)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic [NUM_W-1:0]        num,
   input  logic [DEN_W-1:0]        den,
   input  logic                    neg,
   input  logic [SB_W-1:0]         sb_in,
   output logic                    out_valid,
   output logic signed [QUO_W:0]   quo,
   output logic [SB_W-1:0]         sb_out
);

   localparam int CMP_W = (NUM_W > DEN_W) ? NUM_W : DEN_W;

   logic [QUO_W:0]     v_ff;
   logic [QUO_W:0]     ovf_ff;
   logic [QUO_W:0]     neg_ff;
   logic [DEN_W-1:0]   rem_ff [QUO_W+1];
   logic [DEN_W-1:0]   rem_in [QUO_W+1];
   logic [QUO_W-1:0]   low_ff [QUO_W+1];
   logic [QUO_W-1:0]   low_in [QUO_W+1];
   logic [QUO_W-1:0]   quo_ff [QUO_W+1];
   logic [QUO_W-1:0]   quo_in [QUO_W+1];
   logic [DEN_W-1:0]   den_ff [QUO_W+1];
   logic [SB_W-1:0]    sb_ff  [QUO_W+1];

   logic [CMP_W-1:0]   hi_c;
   logic [CMP_W-1:0]   den_c;
   logic               ovf_c;

   logic               out_v_ff;
   logic signed [QUO_W:0] quo_out_ff;
   logic signed [QUO_W:0] quo_out_in;
   logic [SB_W-1:0]    sb_out_ff;
   logic [QUO_W:0]     mag_c;

   // overflow when the quotient needs more than QUO_W bits
   always_comb begin
      hi_c      = CMP_W'(num >> QUO_W);
      den_c     = CMP_W'(den);
      ovf_c     = hi_c >= den_c;
      rem_in[0] = ovf_c ? '0 : DEN_W'(num >> QUO_W);
      low_in[0] = ovf_c ? '0 : num[QUO_W-1:0];
      quo_in[0] = '0;
   end

   for (genvar k = 1; k <= QUO_W; k++) begin : g_step
      logic [DEN_W:0] trial;
      logic           ge;
      always_comb begin
         trial     = {rem_ff[k-1], low_ff[k-1][QUO_W-1]};
         ge        = trial >= {1'b0, den_ff[k-1]};
         rem_in[k] = ge ? DEN_W'(trial - {1'b0, den_ff[k-1]}) : DEN_W'(trial);
         low_in[k] = {low_ff[k-1][QUO_W-2:0], 1'b0};
         quo_in[k] = {quo_ff[k-1][QUO_W-2:0], ge};
      end
   end

   always_comb begin
      mag_c      = ovf_ff[QUO_W] ? {1'b0, {QUO_W{1'b1}}} : {1'b0, quo_ff[QUO_W]};
      quo_out_in = neg_ff[QUO_W] ? -$signed(mag_c) : $signed(mag_c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         v_ff     <= {v_ff[QUO_W-1:0], in_valid};
         out_v_ff <= v_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem_in[0];
         low_ff[0] <= low_in[0];
         quo_ff[0] <= quo_in[0];
         den_ff[0] <= den;
         sb_ff[0]  <= sb_in;
         ovf_ff    <= {ovf_ff[QUO_W-1:0], ovf_c};
         neg_ff    <= {neg_ff[QUO_W-1:0], neg};
         for (int k = 1; k <= QUO_W; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            quo_ff[k] <= quo_in[k];
            den_ff[k] <= den_ff[k-1];
            sb_ff[k]  <= sb_ff[k-1];
         end
         quo_out_ff <= quo_out_in;
         sb_out_ff  <= sb_ff[QUO_W];
      end
   end

   assign out_valid = out_v_ff;
   assign quo       = quo_out_ff;
   assign sb_out    = sb_out_ff;

endmodule

### hw/rtl/fpd_isqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage.
module fpd_isqrt #(
   parameter int ROOT_W = fpd_pkg::R_W,
   parameter int SB_W   = $bits(fpd_pkg::fpd_carry_type)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [2*ROOT_W-1:0]   rad,
   input  logic [SB_W-1:0]       sb_in,
   output logic                  out_valid,
   output logic [ROOT_W-1:0]     root,
   output logic [SB_W-1:0]       sb_out
);

   logic [ROOT_W:0]        v_ff;
   logic [2*ROOT_W-1:0]    val_ff  [ROOT_W+1];
   logic [2*ROOT_W-1:0]    val_in  [ROOT_W+1];
   logic [ROOT_W+1:0]      rem_ff  [ROOT_W+1];
   logic [ROOT_W+1:0]      rem_in  [ROOT_W+1];
   logic [ROOT_W-1:0]      root_ff [ROOT_W+1];
   logic [ROOT_W-1:0]      root_in [ROOT_W+1];
   logic [SB_W-1:0]        sb_ff   [ROOT_W+1];

   always_comb begin
      val_in[0]  = rad;
      rem_in[0]  = '0;
      root_in[0] = '0;
   end

   for (genvar k = 1; k <= ROOT_W; k++) begin : g_step
      logic [ROOT_W+1:0] remx;
      logic [ROOT_W+1:0] trial;
      logic              ge;
      always_comb begin
         remx       = {rem_ff[k-1][ROOT_W-1:0], val_ff[k-1][2*ROOT_W-1 -: 2]};
         trial      = {root_ff[k-1], 2'b01};
         ge         = remx >= trial;
         rem_in[k]  = ge ? remx - trial : remx;
         root_in[k] = {root_ff[k-1][ROOT_W-2:0], ge};
         val_in[k]  = {val_ff[k-1][2*ROOT_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[ROOT_W-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sb_ff[0] <= sb_in;
         for (int k = 0; k <= ROOT_W; k++) begin
            val_ff[k]  <= val_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
         for (int k = 1; k <= ROOT_W; k++) begin
            sb_ff[k] <= sb_ff[k-1];
         end
      end
   end

   assign out_valid = v_ff[ROOT_W];
   assign root      = root_ff[ROOT_W];
   assign sb_out    = sb_ff[ROOT_W];

endmodule

### hw/rtl/fpd_cordic.sv
`timescale 1ns / 1ps
// Pipelined CORDIC arctangent of a Q.16 radius, one rotation per stage.
module fpd_cordic #(
   parameter int SB_W = $bits(fpd_pkg::fpd_carry_type)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [fpd_pkg::R_W-1:0]   r,
   input  logic [SB_W-1:0]           sb_in,
   output logic                      out_valid,
   output logic [fpd_pkg::TH_W-1:0]  theta,
   output logic [SB_W-1:0]           sb_out
);

   localparam int STEPS = fpd_pkg::CORDIC_STEPS;
   localparam int XY_W  = fpd_pkg::CORDIC_XY_W;
   localparam int Z_W   = fpd_pkg::CORDIC_Z_W;

   logic [STEPS:0]          v_ff;
   logic signed [XY_W-1:0]  x_ff [STEPS+1];
   logic signed [XY_W-1:0]  x_in [STEPS+1];
   logic signed [XY_W-1:0]  y_ff [STEPS+1];
   logic signed [XY_W-1:0]  y_in [STEPS+1];
   logic signed [Z_W-1:0]   z_ff [STEPS+1];
   logic signed [Z_W-1:0]   z_in [STEPS+1];
   logic [SB_W-1:0]         sb_ff [STEPS+1];

   logic                        out_v_ff;
   logic [fpd_pkg::TH_W-1:0]    th_ff;
   logic [fpd_pkg::TH_W-1:0]    th_in;
   logic [SB_W-1:0]             sb_out_ff;

   always_comb begin
      x_in[0] = XY_W'(fpd_pkg::ONE_Q16);
      y_in[0] = $signed(XY_W'(r));
      z_in[0] = '0;
   end

   for (genvar k = 1; k <= STEPS; k++) begin : g_rot
      logic signed [XY_W-1:0] xs;
      logic signed [XY_W-1:0] ys;
      logic signed [Z_W-1:0]  ang;
      always_comb begin
         xs  = x_ff[k-1] >>> (k - 1);
         ys  = y_ff[k-1] >>> (k - 1);
         ang = $signed(Z_W'(fpd_pkg::ATAN_Q16[k-1]));
         if (y_ff[k-1] > 0) begin
            x_in[k] = x_ff[k-1] + ys;
            y_in[k] = y_ff[k-1] - xs;
            z_in[k] = z_ff[k-1] + ang;
         end else begin
            x_in[k] = x_ff[k-1] - ys;
            y_in[k] = y_ff[k-1] + xs;
            z_in[k] = z_ff[k-1] - ang;
         end
      end
   end

   // clamp the angle to [0, half pi]
   always_comb begin
      if (z_ff[STEPS] < 0) begin
         th_in = '0;
      end else if (z_ff[STEPS] > $signed(Z_W'(fpd_pkg::HALF_PI_Q16))) begin
         th_in = fpd_pkg::HALF_PI_Q16;
      end else begin
         th_in = z_ff[STEPS][fpd_pkg::TH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         v_ff     <= {v_ff[STEPS-1:0], in_valid};
         out_v_ff <= v_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sb_ff[0] <= sb_in;
         for (int k = 0; k <= STEPS; k++) begin
            x_ff[k] <= x_in[k];
            y_ff[k] <= y_in[k];
            z_ff[k] <= z_in[k];
         end
         for (int k = 1; k <= STEPS; k++) begin
            sb_ff[k] <= sb_ff[k-1];
         end
         th_ff     <= th_in;
         sb_out_ff <= sb_ff[STEPS];
      end
   end

   assign out_valid = out_v_ff;
   assign theta     = th_ff;
   assign sb_out    = sb_out_ff;

endmodule

### hw/rtl/fisheye_point_distortion.sv
`timescale 1ns / 1ps
// Top level of the equidistant fisheye point distortion pipeline.
//
// Takes one ideal point (Q11.4 pixels) per clock while req_tready is high and
// returns its distorted position under the four-coefficient equidistant
// fisheye model, with a flag when either coordinate saturated. The block is a
// pipeline of 118 register stages: the offset from the principal point, two
// 33-stage dividers that normalise by the focal lengths, squaring and sum, a
// 33-stage square root, an 18-stage CORDIC arctangent, ten stages of theta
// powers and polynomial, two 20-stage dividers that scale the offset by
// theta_d / r, and a saturating output stage. A new transaction is taken every
// cycle unless stalled. The whole pipe holds while the one-entry skid buffer
// behind the output stage is occupied, so req_tready drops only in the cycle
// after a result was refused, and no transaction is lost or repeated. A zero
// radius returns the input point unchanged. Configuration is written through
// the csr port, which is always ready; write it only while the pipe is empty.
module fisheye_point_distortion (
   input  logic                              clock,
   input  logic                              reset,
   // input transactions
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [31:0]                       req_tdata,   // pos_x[15:0], pos_y[31:16]
   // result transactions
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,   // dist_x[15:0], dist_y[31:16]
   output logic                              rsp_tuser,   // clipped[0]
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fpd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fpd_pkg::CSR_DAT_W-1:0]     csr_data
);

   localparam int DX_W   = fpd_pkg::DX_W;
   localparam int POS_W  = fpd_pkg::POS_W;
   localparam int FOC_W  = fpd_pkg::FOCAL_W;
   localparam int COEF_W = fpd_pkg::COEF_W;
   localparam int R_W    = fpd_pkg::R_W;
   localparam int TH_W   = fpd_pkg::TH_W;
   localparam int SB_W   = $bits(fpd_pkg::fpd_carry_type);
   localparam int NUM1_W = DX_W - 1 + 16;
   localparam int Q1_W   = fpd_pkg::NORM_Q;
   localparam int Q2_W   = fpd_pkg::QUO2_Q;
   localparam int NUM2_W = fpd_pkg::NUM2_W;
   localparam int M_W    = 46;
   localparam int POLY_W = 32;
   localparam int PROD_W = 50;
   localparam int NU_W   = 52;
   localparam int SUM_W  = 21;
   localparam int PSTAGES = 10;
   localparam logic signed [SUM_W-1:0] OUT_MAX = 21'sd32767;
   localparam logic signed [SUM_W-1:0] OUT_MIN = -21'sd32768;

   // ---------------------------------------------------------------- registers
   logic [FOC_W-1:0]         focal_x_ff, focal_y_ff, center_x_ff, center_y_ff;
   logic signed [COEF_W-1:0] coef_k1_ff, coef_k2_ff, coef_k3_ff, coef_k4_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= fpd_pkg::FOCAL_RESET;
         focal_y_ff  <= fpd_pkg::FOCAL_RESET;
         center_x_ff <= fpd_pkg::CENTER_X_RESET;
         center_y_ff <= fpd_pkg::CENTER_Y_RESET;
         coef_k1_ff  <= '0;
         coef_k2_ff  <= '0;
         coef_k3_ff  <= '0;
         coef_k4_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            fpd_pkg::REG_FOCAL_X:  focal_x_ff  <= csr_data[FOC_W-1:0];
            fpd_pkg::REG_FOCAL_Y:  focal_y_ff  <= csr_data[FOC_W-1:0];
            fpd_pkg::REG_CENTER_X: center_x_ff <= csr_data[FOC_W-1:0];
            fpd_pkg::REG_CENTER_Y: center_y_ff <= csr_data[FOC_W-1:0];
            fpd_pkg::REG_COEF_K1:  coef_k1_ff  <= $signed(csr_data[COEF_W-1:0]);
            fpd_pkg::REG_COEF_K2:  coef_k2_ff  <= $signed(csr_data[COEF_W-1:0]);
            fpd_pkg::REG_COEF_K3:  coef_k3_ff  <= $signed(csr_data[COEF_W-1:0]);
            fpd_pkg::REG_COEF_K4:  coef_k4_ff  <= $signed(csr_data[COEF_W-1:0]);
            default: ;  // drop writes beyond the map
         endcase
      end
   end

   // ---------------------------------------------------------------- flow control
   // Hold every stage while the skid entry is occupied.
   logic skid_v_ff, skid_v_in;
   logic en;
   assign en         = !skid_v_ff;
   assign req_tready = en;

   // ---------------------------------------------------------------- offset
   logic                   s1_v_ff;
   logic signed [DX_W-1:0] dx_ff, dy_ff, dx_in, dy_in;

   always_comb begin
      dx_in = DX_W'($signed(req_tdata[POS_W-1:0]))      - $signed(DX_W'(center_x_ff));
      dy_in = DX_W'($signed(req_tdata[2*POS_W-1:POS_W])) - $signed(DX_W'(center_y_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
   end

   // ---------------------------------------------------------------- normalise
   logic [DX_W-1:0]         dxm_c, dym_c;
   logic [FOC_W-1:0]        fx_c, fy_c;
   fpd_pkg::fpd_carry_type  c1x_c, c1y_c, n_sbx, n_sby;
   logic [SB_W-1:0]         n_sbx_v, n_sby_v;
   logic                    nx_v, ny_v;
   logic signed [Q1_W:0]    nx, ny;

   always_comb begin
      dxm_c = dx_ff[DX_W-1] ? DX_W'(-dx_ff) : DX_W'(dx_ff);
      dym_c = dy_ff[DX_W-1] ? DX_W'(-dy_ff) : DX_W'(dy_ff);
      // treat a zero focal length as one
      fx_c  = (focal_x_ff == '0) ? FOC_W'(1) : focal_x_ff;
      fy_c  = (focal_y_ff == '0) ? FOC_W'(1) : focal_y_ff;
      c1x_c = '0;
      c1x_c.dx = dx_ff;
      c1y_c = '0;
      c1y_c.dy = dy_ff;
   end

   fpd_divider #(
      .NUM_W (NUM1_W), .DEN_W (FOC_W), .QUO_W (Q1_W), .SB_W (SB_W)
   ) u_norm_x (
      .clock (clock), .reset (reset), .en (en), .in_valid (s1_v_ff),
      .num ({dxm_c[DX_W-2:0], 16'b0}), .den (fx_c), .neg (dx_ff[DX_W-1]),
      .sb_in (c1x_c), .out_valid (nx_v), .quo (nx), .sb_out (n_sbx_v)
   );

   fpd_divider #(
      .NUM_W (NUM1_W), .DEN_W (FOC_W), .QUO_W (Q1_W), .SB_W (SB_W)
   ) u_norm_y (
      .clock (clock), .reset (reset), .en (en), .in_valid (s1_v_ff),
      .num ({dym_c[DX_W-2:0], 16'b0}), .den (fy_c), .neg (dy_ff[DX_W-1]),
      .sb_in (c1y_c), .out_valid (ny_v), .quo (ny), .sb_out (n_sby_v)
   );

   assign n_sbx = n_sbx_v;
   assign n_sby = n_sby_v;

   // ---------------------------------------------------------------- squares and sum
   logic                    sq_v_ff, sum_v_ff;
   logic [63:0]             sqx_ff, sqy_ff, r2_ff;
   fpd_pkg::fpd_carry_type  sq_c_ff, sum_c_ff, sq_c_in;

   always_comb begin
      sq_c_in    = '0;
      sq_c_in.dx = n_sbx.dx;
      sq_c_in.dy = n_sby.dy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff  <= 1'b0;
         sum_v_ff <= 1'b0;
      end else if (en) begin
         sq_v_ff  <= nx_v;
         sum_v_ff <= sq_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff   <= 64'(nx * nx);
         sqy_ff   <= 64'(ny * ny);
         sq_c_ff  <= sq_c_in;
         r2_ff    <= sqx_ff + sqy_ff;
         sum_c_ff <= sq_c_ff;
      end
   end

   // ---------------------------------------------------------------- radius
   logic                    rt_v;
   logic [R_W-1:0]          r_root;
   logic [SB_W-1:0]         rt_sb_v;
   fpd_pkg::fpd_carry_type  rt_sb, at_c_in;

   fpd_isqrt #(.ROOT_W (R_W), .SB_W (SB_W)) u_isqrt (
      .clock (clock), .reset (reset), .en (en), .in_valid (sum_v_ff),
      .rad (r2_ff), .sb_in (sum_c_ff), .out_valid (rt_v), .root (r_root),
      .sb_out (rt_sb_v)
   );

   always_comb begin
      rt_sb     = rt_sb_v;
      at_c_in   = rt_sb;
      at_c_in.r = r_root;
   end

   // ---------------------------------------------------------------- theta
   logic                    at_v;
   logic [TH_W-1:0]         theta;
   logic [SB_W-1:0]         at_sb_v;
   fpd_pkg::fpd_carry_type  at_sb, p_c_in;

   fpd_cordic #(.SB_W (SB_W)) u_cordic (
      .clock (clock), .reset (reset), .en (en), .in_valid (rt_v),
      .r (r_root), .sb_in (at_c_in), .out_valid (at_v), .theta (theta),
      .sb_out (at_sb_v)
   );

   always_comb begin
      at_sb     = at_sb_v;
      p_c_in    = at_sb;
      p_c_in.th = theta;
   end

   // ---------------------------------------------------------------- polynomial
   logic [PSTAGES-1:0]      pv_ff;
   fpd_pkg::fpd_carry_type  pc_ff [PSTAGES];
   logic [17:0]             t2_ff [3];
   logic [19:0]             t4_ff [2];
   logic [21:0]             t6_ff;
   logic [23:0]             t8_ff;
   logic signed [M_W-1:0]   m1_ff, m2_ff, m3_ff, m4_ff, s12_ff, s34_ff, acc_ff;
   logic signed [POLY_W-1:0] poly_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [NU_W-1:0]  nux_ff, nuy_ff;
   logic [NUM2_W-1:0]       magx_ff, magy_ff;
   logic                    negx_ff, negy_ff;
   logic [R_W-1:0]          den2_ff;

   logic [33:0]             th_sq_c;
   logic [35:0]             t2_sq_c;
   logic [37:0]             t26_c;
   logic [39:0]             t44_c;
   logic signed [PROD_W-17:0] thd_c;
   logic signed [NU_W-1:0]  nux_c, nuy_c;

   always_comb begin
      th_sq_c = 34'(p_c_in.th) * 34'(p_c_in.th);
      t2_sq_c = 36'(t2_ff[0]) * 36'(t2_ff[0]);
      t26_c   = 38'(t2_ff[1]) * 38'(t4_ff[0]);
      t44_c   = 40'(t4_ff[0]) * 40'(t4_ff[0]);
      thd_c   = prod_ff[PROD_W-1:16];
      nux_c   = NU_W'(pc_ff[7].dx * thd_c);
      nuy_c   = NU_W'(pc_ff[7].dy * thd_c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
      end else if (en) begin
         pv_ff <= {pv_ff[PSTAGES-2:0], at_v};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pc_ff[0] <= p_c_in;
         for (int k = 1; k < PSTAGES; k++) begin
            pc_ff[k] <= pc_ff[k-1];
         end
         // theta powers
         t2_ff[0] <= th_sq_c[33:16];
         t2_ff[1] <= t2_ff[0];
         t4_ff[0] <= t2_sq_c[35:16];
         t2_ff[2] <= t2_ff[1];
         t4_ff[1] <= t4_ff[0];
         t6_ff    <= t26_c[37:16];
         t8_ff    <= t44_c[39:16];
         // coefficient products
         m1_ff    <= M_W'(coef_k1_ff * $signed({1'b0, t2_ff[2]}));
         m2_ff    <= M_W'(coef_k2_ff * $signed({1'b0, t4_ff[1]}));
         m3_ff    <= M_W'(coef_k3_ff * $signed({1'b0, t6_ff}));
         m4_ff    <= M_W'(coef_k4_ff * $signed({1'b0, t8_ff}));
         s12_ff   <= m1_ff + m2_ff;
         s34_ff   <= m3_ff + m4_ff;
         acc_ff   <= s12_ff + s34_ff;
         poly_ff  <= POLY_W'(acc_ff >>> 16) + POLY_W'(fpd_pkg::ONE_Q16);
         // theta_d before the shift, then the offsets times theta_d
         prod_ff  <= PROD_W'($signed({1'b0, pc_ff[6].th}) * poly_ff);
         nux_ff   <= nux_c;
         nuy_ff   <= nuy_c;
         magx_ff  <= nux_ff[NU_W-1] ? NUM2_W'(-nux_ff) : NUM2_W'(nux_ff);
         magy_ff  <= nuy_ff[NU_W-1] ? NUM2_W'(-nuy_ff) : NUM2_W'(nuy_ff);
         negx_ff  <= nux_ff[NU_W-1];
         negy_ff  <= nuy_ff[NU_W-1];
         den2_ff  <= (pc_ff[8].r == '0) ? R_W'(1) : pc_ff[8].r;
      end
   end

   // ---------------------------------------------------------------- scale by theta_d / r
   logic                    qx_v, qy_v;
   logic signed [Q2_W:0]    qx, qy;
   logic [SB_W-1:0]         q_sbx_v, q_sby_v;
   fpd_pkg::fpd_carry_type  q_sbx, q_sby;

   fpd_divider #(
      .NUM_W (NUM2_W), .DEN_W (R_W), .QUO_W (Q2_W), .SB_W (SB_W)
   ) u_scale_x (
      .clock (clock), .reset (reset), .en (en), .in_valid (pv_ff[PSTAGES-1]),
      .num (magx_ff), .den (den2_ff), .neg (negx_ff), .sb_in (pc_ff[PSTAGES-1]),
      .out_valid (qx_v), .quo (qx), .sb_out (q_sbx_v)
   );

   fpd_divider #(
      .NUM_W (NUM2_W), .DEN_W (R_W), .QUO_W (Q2_W), .SB_W (SB_W)
   ) u_scale_y (
      .clock (clock), .reset (reset), .en (en), .in_valid (pv_ff[PSTAGES-1]),
      .num (magy_ff), .den (den2_ff), .neg (negy_ff), .sb_in (pc_ff[PSTAGES-1]),
      .out_valid (qy_v), .quo (qy), .sb_out (q_sby_v)
   );

   assign q_sbx = q_sbx_v;
   assign q_sby = q_sby_v;

   // ---------------------------------------------------------------- saturate
   logic                    last_v_ff;
   logic [31:0]             last_data_ff, last_data_in;
   logic                    last_clip_ff, last_clip_in;
   logic signed [SUM_W-1:0] ox_c, oy_c, vx_c, vy_c;
   logic [POS_W-1:0]        rx_c, ry_c;
   logic                    clx_c, cly_c;

   always_comb begin
      // zero radius: keep the offset as it is
      ox_c = (q_sbx.r == '0) ? SUM_W'(q_sbx.dx) : SUM_W'(qx);
      oy_c = (q_sby.r == '0) ? SUM_W'(q_sby.dy) : SUM_W'(qy);
      vx_c = $signed(SUM_W'(center_x_ff)) + ox_c;
      vy_c = $signed(SUM_W'(center_y_ff)) + oy_c;
      clx_c = (vx_c > OUT_MAX) || (vx_c < OUT_MIN);
      cly_c = (vy_c > OUT_MAX) || (vy_c < OUT_MIN);
      if (vx_c > OUT_MAX) begin
         rx_c = OUT_MAX[POS_W-1:0];
      end else if (vx_c < OUT_MIN) begin
         rx_c = OUT_MIN[POS_W-1:0];
      end else begin
         rx_c = vx_c[POS_W-1:0];
      end
      if (vy_c > OUT_MAX) begin
         ry_c = OUT_MAX[POS_W-1:0];
      end else if (vy_c < OUT_MIN) begin
         ry_c = OUT_MIN[POS_W-1:0];
      end else begin
         ry_c = vy_c[POS_W-1:0];
      end
      last_data_in = {ry_c, rx_c};
      last_clip_in = clx_c || cly_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_v_ff <= 1'b0;
      end else if (en) begin
         last_v_ff <= qx_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         last_data_ff <= last_data_in;
         last_clip_ff <= last_clip_in;
      end
   end

   // ---------------------------------------------------------------- skid entry
   // Park a refused result here while the pipe moves on, and hold the pipe until it is taken.
   logic [31:0] skid_data_ff;
   logic        skid_clip_ff;

   always_comb begin
      skid_v_in = skid_v_ff;
      if (en) begin
         skid_v_in = last_v_ff && !rsp_tready;
      end else if (rsp_tready) begin
         skid_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
      end else begin
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         skid_data_ff <= last_data_ff;
         skid_clip_ff <= last_clip_ff;
      end
   end

   assign rsp_tvalid = skid_v_ff || last_v_ff;
   assign rsp_tdata  = skid_v_ff ? skid_data_ff : last_data_ff;
   assign rsp_tuser  = skid_v_ff ? skid_clip_ff : last_clip_ff;

   // ---------------------------------------------------------------- checks
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(last_v_ff && !rsp_tready))
      else $error("skid entry filled without a refused result");

   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff && !rsp_tready |=> skid_v_ff)
      else $error("parked result dropped before it was taken");

   a_pipe_frozen: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |=> last_v_ff == $past(last_v_ff))
      else $error("output stage moved while the skid entry was occupied");

   a_norm_lockstep: assert property (@(posedge clock) disable iff (reset)
      nx_v == ny_v && qx_v == qy_v)
      else $error("x and y dividers out of step");

endmodule

### tb/tb_fisheye_point_distortion.sv
`timescale 1ns / 1ps
// Testbench for the fisheye point distortion pipeline under several lens settings.
module tb_fisheye_point_distortion;

   typedef struct {
      logic signed [15:0] dist_x;
      logic signed [15:0] dist_y;
      logic               clipped;
   } point_result_type;

   // Predicts distorted points and holds them in order until the block returns them.
   class distortion_scoreboard;
      logic [19:0]      lens_reg [8];
      point_result_type pending [$];
      int               fail_count;

      function new();
         lens_reg[0] = 8192; lens_reg[1] = 8192; lens_reg[2] = 10240; lens_reg[3] = 7680;
         for (int i = 4; i < 8; i++) lens_reg[i] = 0;
         fail_count = 0;
      endfunction

      function void write_reg(int idx, logic [19:0] val);
         if (idx < 8) lens_reg[idx] = (idx < 4) ? {4'b0, val[15:0]} : val;
      endfunction

      function longint floor_shift(longint v, int s);
         return (v >= 0) ? (v >>> s) : -((-(v + 1)) >>> s) - 1;
      endfunction

      function longint to_unit(longint d, longint focal);
         longint f, n;
         f = (focal == 0) ? 1 : focal;
         n = (d * 65536) / f;
         if (n > 64'sd2147483647) n = 64'sd2147483647;
         if (n < -64'sd2147483647) n = -64'sd2147483647;
         return n;
      endfunction

      function longint root_floor(logic [63:0] v);
         logic [63:0] res, bitv;
         res = 0; bitv = 64'd1 << 62;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v -= res + bitv;
               res = (res >> 1) + bitv;
            end else res >>= 1;
            bitv >>= 2;
         end
         return longint'(res);
      endfunction

      function longint arctan_q16(longint r);
         longint x, y, z, xs, ys;
         x = 65536; y = r; z = 0;
         for (int i = 0; i < fpd_pkg::CORDIC_STEPS; i++) begin
            xs = floor_shift(x, i); ys = floor_shift(y, i);
            if (y > 0) begin
               x += ys; y -= xs; z += longint'(fpd_pkg::ATAN_Q16[i]);
            end else begin
               x -= ys; y += xs; z -= longint'(fpd_pkg::ATAN_Q16[i]);
            end
         end
         if (z < 0) z = 0;
         if (z > 102944) z = 102944;
         return z;
      endfunction

      function longint saturate(longint v, ref logic clip);
         if (v > 32767) begin v = 32767; clip = 1; end
         if (v < -32768) begin v = -32768; clip = 1; end
         return v;
      endfunction

      // Note an accepted point and queue its predicted distortion.
      function void note_point(logic signed [15:0] px, logic signed [15:0] py);
         longint cx, cy, dx, dy, qx, qy, nx, ny, r, th, t2, t4, t6, t8, acc, thd;
         logic [63:0] r2;
         point_result_type e;
         logic clip;
         cx = lens_reg[2]; cy = lens_reg[3];
         dx = longint'(px) - cx; dy = longint'(py) - cy;
         qx = dx; qy = dy; clip = 0;
         nx = to_unit(dx, lens_reg[0]); ny = to_unit(dy, lens_reg[1]);
         r2 = 64'(nx * nx) + 64'(ny * ny);
         r = root_floor(r2);
         if (r > 0) begin
            th = arctan_q16(r);
            t2 = (th * th) >>> 16; t4 = (t2 * t2) >>> 16;
            t6 = (t2 * t4) >>> 16; t8 = (t4 * t4) >>> 16;
            acc = longint'($signed(lens_reg[4])) * t2 + longint'($signed(lens_reg[5])) * t4
                + longint'($signed(lens_reg[6])) * t6 + longint'($signed(lens_reg[7])) * t8;
            thd = floor_shift(th * (65536 + floor_shift(acc, 16)), 16);
            qx = (dx * thd) / r; qy = (dy * thd) / r;
         end
         e.dist_x = 16'(saturate(cx + qx, clip));
         e.dist_y = 16'(saturate(cy + qy, clip));
         e.clipped = clip;
         pending.push_back(e);
      endfunction

      // Check a returned point against the oldest prediction.
      function void check_point(logic [31:0] data, logic flag);
         point_result_type e;
         if (pending.size() == 0) begin
            $error("unexpected result %h", data);
            fail_count++;
            return;
         end
         e = pending.pop_front();
         if (data[15:0] !== e.dist_x) begin
            $error("dist_x expected %0d actual %0d", e.dist_x, $signed(data[15:0]));
            fail_count++;
         end
         if (data[31:16] !== e.dist_y) begin
            $error("dist_y expected %0d actual %0d", e.dist_y, $signed(data[31:16]));
            fail_count++;
         end
         if (flag !== e.clipped) begin
            $error("clipped expected %0d actual %0d", e.clipped, flag);
            fail_count++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [fpd_pkg::CSR_IDX_W-1:0] csr_index = 0;
   logic [fpd_pkg::CSR_DAT_W-1:0] csr_data = 0;

   distortion_scoreboard board = new();
   bit stall_free;   // run the receiver without stalls for a stretch

   fisheye_point_distortion uut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Drive one register write; the port is always ready but wait for it anyway.
   task automatic write_lens(logic [fpd_pkg::CSR_IDX_W-1:0] idx, logic [19:0] val);
      csr_valid <= 1; csr_index <= idx; csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, val);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   // Send one point, with a random gap before it unless the stretch is gap free.
   task automatic send_point(logic [15:0] px, logic [15:0] py, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1; req_tdata <= {py, px};
      do @(posedge clock); while (!req_tready);
      board.note_point(px, py);
   endtask

   // Let the pipe drain before the lens settings change.
   task automatic drain_pipe();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (130) @(posedge clock);
   endtask

   // Receiver: stall at random, except in gap-free stretches.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_point(rsp_tdata, rsp_tuser);
      end
   end

   initial begin : receiver
      int wait_cycles;
      @(negedge reset);
      forever begin
         wait_cycles = stall_free ? 0 : $urandom_range(0, 17);
         if (wait_cycles != 0) begin
            rsp_tready <= 0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   function automatic logic [15:0] rand_pos(logic [15:0] centre);
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return centre + 16'($signed($urandom_range(0, 8191)) - 4096);
         2: return centre + 16'($signed($urandom_range(0, 127)) - 64);
         default: return centre;
      endcase
   endfunction

   initial begin : stimulus
      logic [15:0] cx, cy;
      bit burst;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed points at reset settings: the centre itself, field extremes.
      send_point(16'd10240, 16'd7680, 0);
      send_point(16'h8000, 16'h8000, 0);
      send_point(16'h7fff, 16'h7fff, 0);
      send_point(16'h7fff, 16'h8000, 0);
      send_point(16'h0000, 16'hffff, 0);
      send_point(16'd10241, 16'd7680, 0);
      drain_pipe();

      // Strong coefficients, tiny and zero focal lengths: clamping and mirroring.
      write_lens(fpd_pkg::REG_COEF_K1, 20'h80000);
      write_lens(fpd_pkg::REG_COEF_K2, 20'h7ffff);
      write_lens(fpd_pkg::REG_COEF_K3, 20'h80000);
      write_lens(fpd_pkg::REG_COEF_K4, 20'h7ffff);
      write_lens(fpd_pkg::REG_FOCAL_X, 16'd0);
      write_lens(fpd_pkg::REG_FOCAL_Y, 16'd1);
      write_lens(fpd_pkg::REG_CENTER_X, 16'hffff);
      write_lens(fpd_pkg::REG_CENTER_Y, 16'h0000);
      send_point(16'hffff, 16'h0000, 0);
      send_point(16'h8000, 16'h7fff, 0);
      send_point(16'h0000, 16'h0001, 0);
      send_point(16'h7fff, 16'hffff, 0);
      drain_pipe();
      write_lens(fpd_pkg::REG_FOCAL_X, 16'hffff);
      write_lens(fpd_pkg::REG_FOCAL_Y, 16'd16);
      write_lens(4'd9, 20'h12345);   // unmapped index, must be ignored
      send_point(16'h8000, 16'h8000, 0);
      send_point(16'h7fff, 16'h7fff, 0);
      send_point(16'h1234, 16'h0010, 0);
      drain_pipe();

      // Random phases, each with fresh lens settings.
      for (int phase = 0; phase < 8; phase++) begin
         cx = (phase == 0) ? 16'd0 : 16'($urandom);
         cy = (phase == 0) ? 16'hffff : 16'($urandom);
         write_lens(fpd_pkg::REG_FOCAL_X,
                    (phase == 1) ? 20'd16 : 20'($urandom_range(16, 65535)));
         write_lens(fpd_pkg::REG_FOCAL_Y,
                    (phase == 1) ? 20'd65535 : 20'($urandom_range(16, 65535)));
         write_lens(fpd_pkg::REG_CENTER_X, cx);
         write_lens(fpd_pkg::REG_CENTER_Y, cy);
         for (int k = 0; k < 4; k++)
            write_lens(fpd_pkg::REG_COEF_K1 + k[3:0], (phase < 4) ?
                       20'($signed($urandom_range(0, 40000)) - 20000) : 20'($urandom));
         for (int n = 0; n < 55; n++) begin
            burst = (n % 20) >= 14;
            stall_free = burst;
            send_point(rand_pos(cx), rand_pos(cy), burst);
         end
         stall_free = 0;
         drain_pipe();
      end

      if (board.fail_count == 0 && board.pending.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #20ms;
      $display("status: fail");
      $finish;
   end
endmodule
